// ===== rtl/core/scec_pkg.sv =====
package scec_pkg;

  localparam int unsigned LineWidth = 1024;
  localparam int unsigned MaxLines  = 16;

  localparam int unsigned ColW    = 10;
  localparam int unsigned BrightW = 10;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned CntW    = 11;
  localparam int unsigned SumW    = 20;
  localparam int unsigned LineW   = 4;
  // Scaled step and scaled threshold are both compared at this width.
  localparam int unsigned CmpW    = 14;

  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  localparam logic [ThrW-1:0] ThrReset = ThrW'(300);

  typedef struct packed {
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [ColW-1:0] column;
    logic            end_of_line;
    logic            start_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [LineW-1:0] line_number;
    logic [ColW-1:0]  centroid;
    logic [CntW-1:0]  edge_count;
    logic             found;
  } line_result_t;

endpackage

// ===== rtl/core/scec_div.sv =====
module scec_div
  import scec_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output logic            done_o,
  output logic [SumW-1:0] quotient_o
);

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of quo_q from the top while quotient bits shift in at the bottom.
  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  div_q;
  logic [SumW-1:0]  quo_q;

  logic [CntW:0]    rem_sh;
  logic [CntW+1:0]  trial;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, div_q};
  assign fits   = !trial[CntW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[CntW-1:0] : rem_sh[CntW-1:0];
      quo_q <= {quo_q[SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/scanline_edge_centroid_unit.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i   (pixel_t)
// out       output     out_valid_o / out_ready_i out_data_o  (line_result_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (edge threshold)
//
// A pixel that does not end a line is taken, and the next may follow at once.
// A pixel that ends a line starts the serial divider (one quotient bit per
// cycle, 20 bits); the next item is taken only after the divider is done
// and its result is in the output register. A new item is accepted while
// it waits; after a second line end, input stalls until the first is taken.
// Reset restores threshold 300, clears running line state; no clearing pass.
module scanline_edge_centroid_unit
  import scec_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pixel_t          in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output line_result_t    out_data_o,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StHold
  } state_e;

  state_e           state_q;
  logic [ThrW-1:0]  thr_q;
  logic [BrightW-1:0] prev_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  cnt_q;
  logic [LineW-1:0] line_q;
  logic [LineW-1:0] res_line_q;
  logic [CntW-1:0]  res_cnt_q;
  logic             out_valid_q;
  line_result_t     out_q;

  logic               accept;
  logic [BrightW-1:0] bright;
  logic [BrightW-1:0] prev_eff;
  logic [BrightW-1:0] diff;
  logic [CmpW-1:0]    diff_x10;
  logic [CmpW-1:0]    thr_x3;
  logic               is_edge;
  logic [SumW-1:0]    base_sum;
  logic [CntW-1:0]    base_cnt;
  logic [LineW-1:0]   base_line;
  logic [SumW-1:0]    sum_d;
  logic [CntW-1:0]    cnt_d;
  logic [LineW-1:0]   line_next;
  logic               div_done;
  logic [SumW-1:0]    quotient;
  logic               out_free;
  logic               res_load;
  line_result_t       result;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    bright = BrightW'(in_data_i.red) + BrightW'(in_data_i.green)
           + BrightW'(in_data_i.blue);
    prev_eff = in_data_i.start_of_frame ? bright : prev_q;
    diff = (bright >= prev_eff) ? bright - prev_eff : prev_eff - bright;
    diff_x10 = (CmpW'(diff) << 3) + (CmpW'(diff) << 1);
    thr_x3   = (CmpW'(thr_q) << 1) + CmpW'(thr_q);

    base_sum  = in_data_i.start_of_frame ? '0 : sum_q;
    base_cnt  = in_data_i.start_of_frame ? '0 : cnt_q;
    base_line = in_data_i.start_of_frame ? '0 : line_q;

    // Once the count reaches the line width, further edges are dropped.
    is_edge = (diff_x10 > thr_x3) && (base_cnt < CntW'(LineWidth));
    sum_d   = base_sum + (is_edge ? SumW'(in_data_i.column) : '0);
    cnt_d   = base_cnt + CntW'(is_edge);

    line_next = (base_line == LineW'(MaxLines - 1)) ? '0 : base_line + LineW'(1);
  end

  scec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && in_data_i.end_of_line),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign res_load = ((state_q == StDiv) && div_done && out_free) ||
                    ((state_q == StHold) && out_free);

  always_comb begin
    result.line_number = res_line_q;
    result.edge_count  = res_cnt_q;
    result.found       = (res_cnt_q != '0);
    result.centroid    = result.found ? quotient[ColW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thr_q       <= ThrReset;
      prev_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            prev_q <= bright;
            if (in_data_i.end_of_line) begin
              sum_q   <= '0;
              cnt_q   <= '0;
              line_q  <= line_next;
              state_q <= StDiv;
            end else begin
              sum_q  <= sum_d;
              cnt_q  <= cnt_d;
              line_q <= base_line;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            if (out_free) begin
              state_q <= StIdle;
            end else begin
              state_q <= StHold;
            end
          end
        end
        StHold: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.end_of_line) begin
      res_line_q <= base_line;
      res_cnt_q  <= cnt_d;
    end
    if (res_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A line end always hands the line to the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.end_of_line) |=> (state_q == StDiv))
    else $error("line end did not start the divider");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  // The running edge count never passes the line width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LineWidth))
    else $error("edge count beyond line width");

  // A line without edges reports a zero centroid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |->
      (out_data_o.centroid == '0 && out_data_o.edge_count == '0))
    else $error("empty line carries a centroid");

  // A waiting result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("pending result changed");

endmodule
